@@ hw/rtl/rmsn_pkg.sv @@
// shared types and constants of the rms normalization block
package rmsn_pkg;
	localparam int SUM_W = 44;
	localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};
	localparam logic [31:0] ONE_Q24 = 32'h0100_0000;
	localparam logic [31:0] SEED_LOW = 32'd912680550;
	localparam logic [31:0] SEED_HIGH = 32'd644245094;
	localparam logic [32:0] THREE_Q30 = 33'h0_C000_0000;
	localparam logic [0:0] REG_LENGTH = 1'b0;
	localparam logic [0:0] REG_EPSILON = 1'b1;

	typedef struct packed {
		logic [15:0] normalized;
		logic        saturated;
	} out_word_t;

	typedef struct packed {
		logic        mode;
		logic [15:0] sample;
		logic [15:0] weight;
		logic        final_element;
	} in_word_t;
endpackage

@@ hw/rtl/rmsn_if.sv @@
// valid/ready channel interfaces
interface rmsn_in_if;
	import rmsn_pkg::*;
	logic     valid;
	logic     ready;
	in_word_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface rmsn_out_if;
	import rmsn_pkg::*;
	logic      valid;
	logic      ready;
	out_word_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface rmsn_cfg_if;
	logic        valid;
	logic        ready;
	logic [0:0]  index;
	logic [15:0] wdata;
	modport source (output valid, output index, output wdata, input ready);
	modport sink (input valid, input index, input wdata, output ready);
endinterface

@@ hw/rtl/rms_normalize_top.sv @@
// top level of the rms normalization block
// accumulate word: accept, square, add; apply word: accept, two passes of the
// shared 33x33 multiplier, rounding into the output register, which waits on
// out_ch.ready; a final accumulate word adds the divider, normalize, the N1, N2 and N3
// multiplier passes of each newton step, and scaling
// reset clears the sum, sets the scale to one, length 1, epsilon 1
module rms_normalize_top import rmsn_pkg::*; #(
	parameter int MAX_LENGTH = 4096,
	parameter int NEWTON_STEPS = 4
) (
	input logic          clk,
	input logic          arst_n,
	rmsn_in_if.sink      in_ch,
	rmsn_out_if.source   out_ch,
	rmsn_cfg_if.sink     cfg
);
	typedef enum logic [11:0] {
		S_IDLE  = 12'b000000000001,
		S_SQ    = 12'b000000000010,
		S_ACC   = 12'b000000000100,
		S_DIV   = 12'b000000001000,
		S_NORM  = 12'b000000010000,
		S_N1    = 12'b000000100000,
		S_N2    = 12'b000001000000,
		S_N3    = 12'b000010000000,
		S_FIN   = 12'b000100000000,
		S_A1    = 12'b001000000000,
		S_A2    = 12'b010000000000,
		S_A3    = 12'b100000000000
	} state_t;

	state_t state_q;
	logic [SUM_W-1:0] sum_q;
	logic [31:0] scale_q;
	logic [12:0] len_q;
	logic [15:0] eps_q;
	in_word_t    item_q;
	logic [63:0] prod_q;
	logic [31:0] y_q;
	logic [31:0] a_q;
	logic [5:0]  s_q;
	logic [3:0]  step_q;
	logic        fin_flag_q;
	out_word_t   out_q;
	logic        out_valid_q;

	// shared multiplier: one 33x33 signed product per pass
	logic [32:0] mul_a, mul_b;
	logic [63:0] mul_p;
	logic signed [65:0] mul_full;
	assign mul_full = $signed(mul_a) * $signed(mul_b);
	assign mul_p = mul_full[63:0];

	// effective divisor, clamp to [1, MAX_LENGTH]
	logic [12:0] len_eff;
	always_comb begin
		if (len_q == '0) len_eff = 13'd1;
		else if (32'(len_q) > MAX_LENGTH) len_eff = 13'(MAX_LENGTH);
		else len_eff = len_q;
	end

	// square added to the sum, saturating at the top
	logic [SUM_W:0]   sum_add;
	logic [SUM_W-1:0] sum_next;
	assign sum_add = {1'b0, sum_q} + {1'b0, 12'b0, prod_q[31:0]};
	assign sum_next = sum_add[SUM_W] ? SUM_MAX : sum_add[SUM_W-1:0];

	// divider starts on the sum that includes the final square
	logic             div_start, div_done;
	logic [SUM_W-1:0] div_quo;
	rmsn_div u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start), .dividend(sum_next),
		.divisor(len_eff), .done(div_done), .quotient(div_quo)
	);
	assign div_start = state_q == S_ACC && fin_flag_q;

	// mean square and normalize shift
	logic [SUM_W:0] mean;
	logic [5:0] msb;
	logic [5:0] s_even;
	logic [31:0] a_norm;
	assign mean = {1'b0, div_quo} + {{(SUM_W-15){1'b0}}, eps_q};
	always_comb begin
		msb = '0;
		for (int i = 0; i <= SUM_W; i++) if (mean[i]) msb = 6'(i);
	end
	assign s_even = {msb[5:1], 1'b0};
	always_comb begin
		logic [76:0] wide;
		wide = {32'b0, mean};
		if (s_even <= 6'd30) a_norm = 32'(wide << (6'd30 - s_even));
		else a_norm = 32'(wide >> (s_even - 6'd30));
	end

	// newton difference
	logic [32:0] t_val;
	logic [32:0] d_val;
	assign t_val = prod_q[62:30];
	assign d_val = (t_val < THREE_Q30) ? THREE_Q30 - t_val : 33'd0;

	// final scaling of y
	logic [31:0] scale_new;
	logic [4:0]  h;
	always_comb begin
		logic [38:0] up;
		logic [4:0]  sh;
		logic [32:0] rnd;
		h = s_q[5:1];
		up = {7'b0, y_q} << (5'd6 - h);
		sh = h - 5'd6;
		rnd = 33'(y_q) + (33'd1 << (sh - 5'd1));
		if (h <= 5'd6) scale_new = (|up[38:32]) ? 32'hFFFF_FFFF : up[31:0];
		else scale_new = 32'(rnd >> sh);
	end

	// apply rounding of the Q28.36 product
	logic signed [63:0] q_val;
	logic signed [27:0] r_val;
	out_word_t res;
	assign q_val = $signed(prod_q) + 64'sh8_0000_0000;
	assign r_val = 28'(q_val >>> 36);
	always_comb begin
		if (r_val > 28'sd32767) res = '{16'h7FFF, 1'b1};
		else if (r_val < -28'sd32768) res = '{16'h8000, 1'b1};
		else res = '{r_val[15:0], 1'b0};
	end

	// multiplier operand selection by state
	// apply: sample times weight first (fits 33 bits), then times the scale
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		unique case (state_q)
			S_SQ: begin
				mul_a = 33'(signed'(item_q.sample));
				mul_b = 33'(signed'(item_q.sample));
			end
			S_N1: begin mul_a = {1'b0, y_q}; mul_b = {1'b0, y_q}; end
			S_N2: begin mul_a = {1'b0, prod_q[61:30]}; mul_b = {1'b0, a_q}; end
			S_N3: begin mul_a = {1'b0, y_q}; mul_b = d_val; end
			S_A1: begin
				mul_a = 33'(signed'(item_q.sample));
				mul_b = 33'(signed'(item_q.weight));
			end
			S_A2: begin
				mul_a = prod_q[32:0];
				mul_b = {1'b0, scale_q};
			end
			default: ;
		endcase
	end

	logic in_acc;
	logic out_load;
	assign in_ch.ready = state_q == S_IDLE;
	assign in_acc = in_ch.valid && in_ch.ready;
	assign cfg.ready = 1'b1;
	assign out_ch.valid = out_valid_q;
	assign out_ch.data = out_q;
	// result register takes a new word when empty or being drained
	assign out_load = state_q == S_A3 && (!out_valid_q || out_ch.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			sum_q       <= '0;
			scale_q     <= ONE_Q24;
			len_q       <= 13'd1;
			eps_q       <= 16'd1;
			out_valid_q <= 1'b0;
			fin_flag_q  <= 1'b0;
			step_q      <= '0;
		end else begin
			if (cfg.valid) begin
				if (cfg.index == REG_LENGTH) len_q <= cfg.wdata[12:0];
				else eps_q <= cfg.wdata;
			end
			if (out_load) out_valid_q <= 1'b1;
			else if (out_ch.ready) out_valid_q <= 1'b0;
			unique case (state_q)
				S_IDLE: if (in_acc) begin
					fin_flag_q <= in_ch.data.final_element;
					state_q <= in_ch.data.mode ? S_A1 : S_SQ;
				end
				S_SQ: state_q <= S_ACC;
				S_ACC: begin
					sum_q <= sum_next;
					state_q <= fin_flag_q ? S_DIV : S_IDLE;
				end
				S_DIV: if (div_done) state_q <= S_NORM;
				S_NORM: begin
					sum_q <= '0;
					step_q <= '0;
					if (mean == '0) begin
						scale_q <= 32'hFFFF_FFFF;
						state_q <= S_IDLE;
					end else state_q <= S_N1;
				end
				S_N1: state_q <= S_N2;
				S_N2: state_q <= S_N3;
				S_N3: begin
					step_q <= step_q + 4'd1;
					state_q <= (step_q == 4'(NEWTON_STEPS - 1)) ? S_FIN : S_N1;
				end
				S_FIN: begin
					scale_q <= scale_new;
					state_q <= S_IDLE;
				end
				S_A1: state_q <= S_A2;
				S_A2: state_q <= S_A3;
				S_A3: if (out_load) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (in_acc) item_q <= in_ch.data;
		unique case (state_q)
			S_SQ, S_N1, S_N2, S_A1, S_A2: prod_q <= mul_p;
			S_NORM: begin
				a_q <= a_norm;
				s_q <= s_even;
				y_q <= (a_norm < 32'h8000_0000) ? SEED_LOW : SEED_HIGH;
			end
			S_N3: y_q <= mul_p[62:31];
			S_A3: if (out_load) out_q <= res;
			default: ;
		endcase
	end

	// no input taken while the divider runs for a scale computation
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DIV) |-> !in_ch.ready) else $error("ready during divide");
	// a result follows only from an apply word
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q) == S_A3) else $error("stray result");
	// the sum is cleared after each scale computation
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_NORM) |=> sum_q == '0) else $error("sum not cleared");
endmodule

@@ hw/rtl/rmsn_div.sv @@
// restoring divider, one quotient bit per cycle
module rmsn_div import rmsn_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [SUM_W-1:0] dividend,
	input  logic [12:0]      divisor,
	output logic             done,
	output logic [SUM_W-1:0] quotient
);
	logic [SUM_W-1:0] quo_q;
	logic [13:0]      rem_q;
	logic [5:0]       cnt_q;
	logic             busy_q;
	logic [14:0]      trial;

	assign trial = {rem_q, quo_q[SUM_W-1]} - {2'b0, divisor};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 6'd1;
			if (cnt_q == 6'(SUM_W - 1)) busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
		end else if (busy_q) begin
			if (!trial[14]) begin
				rem_q <= trial[13:0];
				quo_q <= {quo_q[SUM_W-2:0], 1'b1};
			end else begin
				rem_q <= {rem_q[12:0], quo_q[SUM_W-1]};
				quo_q <= {quo_q[SUM_W-2:0], 1'b0};
			end
		end
	end

	assign done = busy_q && cnt_q == 6'(SUM_W - 1);
	assign quotient = quo_q;
endmodule
